@@ src/sfe_pkg.sv @@
// Shared types, codes and the step program of the sinusoid frequency estimator.
`timescale 1ns / 1ps
package sfe_pkg;

	// Controller states, one-hot.
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_BUSY = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

	typedef enum logic [2:0] {
		UK_MUL,
		UK_ADD,
		UK_ROOT,
		UK_END,
		UK_HALT
	} ukind_t;

	typedef enum logic [4:0] {
		SRC_A, SRC_B, SRC_K, SRC_DT, SRC_Y, SRC_X1, SRC_SIG, SRC_TH,
		SRC_R0, SRC_R1, SRC_XD, SRC_T1, SRC_T2, SRC_T3, SRC_KB,
		SRC_OMEGA, SRC_INV
	} src_t;

	typedef enum logic [3:0] {
		DST_NONE, DST_R0, DST_R1, DST_XD, DST_T1, DST_T2, DST_T3, DST_KB,
		DST_X1, DST_SIG, DST_TH, DST_FREQ, DST_REINIT
	} dst_t;

	// Product scaling: fraction bits, the 32 bits of the period, or none.
	typedef enum logic [1:0] {
		SH_Q,
		SH_32,
		SH_RAW
	} shsel_t;

	typedef struct packed {
		ukind_t kind;
		src_t   sa;
		src_t   sb;
		logic   na;
		logic   nb;
		shsel_t sh;
		dst_t   dst;
	} uop_t;

	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] STEP_FIRST = 5'd0;
	localparam logic [STEP_W-1:0] STEP_INIT  = 5'd24;

	localparam logic [1:0] REG_FILTER = 2'd0;
	localparam logic [1:0] REG_OBS    = 2'd1;
	localparam logic [1:0] REG_EST    = 2'd2;
	localparam logic [1:0] REG_PERIOD = 2'd3;

	// round(2^32 / (2*pi))
	localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;

	function automatic uop_t mk(input ukind_t k, input src_t a, input src_t b,
			input logic na, input logic nb, input shsel_t s, input dst_t d);
		uop_t u;
		u.kind = k;
		u.sa   = a;
		u.sb   = b;
		u.na   = na;
		u.nb   = nb;
		u.sh   = s;
		u.dst  = d;
		return u;
	endfunction

	// One observer update, then the root and the frequency scaling;
	// the reload of sigma and theta after a coefficient write sits at the end.
	function automatic uop_t ucode(input logic [STEP_W-1:0] step);
		uop_t u;
		case (step)
			5'd0:  u = mk(UK_MUL, SRC_A, SRC_X1, 1'b0, 1'b0, SH_Q, DST_R0);
			5'd1:  u = mk(UK_MUL, SRC_B, SRC_Y, 1'b0, 1'b0, SH_Q, DST_R1);
			5'd2:  u = mk(UK_ADD, SRC_R0, SRC_R1, 1'b1, 1'b0, SH_Q, DST_XD);
			5'd3:  u = mk(UK_MUL, SRC_K, SRC_X1, 1'b0, 1'b0, SH_Q, DST_R0);
			5'd4:  u = mk(UK_MUL, SRC_R0, SRC_X1, 1'b0, 1'b0, SH_Q, DST_R0);
			5'd5:  u = mk(UK_MUL, SRC_R0, SRC_TH, 1'b0, 1'b0, SH_Q, DST_T1);
			5'd6:  u = mk(UK_MUL, SRC_K, SRC_A, 1'b0, 1'b0, SH_Q, DST_R0);
			5'd7:  u = mk(UK_MUL, SRC_R0, SRC_X1, 1'b0, 1'b0, SH_Q, DST_R0);
			5'd8:  u = mk(UK_MUL, SRC_R0, SRC_XD, 1'b0, 1'b0, SH_Q, DST_T2);
			5'd9:  u = mk(UK_MUL, SRC_K, SRC_B, 1'b0, 1'b0, SH_Q, DST_KB);
			5'd10: u = mk(UK_MUL, SRC_KB, SRC_XD, 1'b0, 1'b0, SH_Q, DST_R0);
			5'd11: u = mk(UK_MUL, SRC_R0, SRC_Y, 1'b0, 1'b0, SH_Q, DST_T3);
			5'd12: u = mk(UK_ADD, SRC_T1, SRC_T2, 1'b1, 1'b1, SH_Q, DST_R0);
			5'd13: u = mk(UK_ADD, SRC_R0, SRC_T3, 1'b0, 1'b1, SH_Q, DST_R0);
			5'd14: u = mk(UK_MUL, SRC_XD, SRC_DT, 1'b0, 1'b0, SH_32, DST_R1);
			5'd15: u = mk(UK_ADD, SRC_X1, SRC_R1, 1'b0, 1'b0, SH_Q, DST_X1);
			5'd16: u = mk(UK_MUL, SRC_R0, SRC_DT, 1'b0, 1'b0, SH_32, DST_R1);
			5'd17: u = mk(UK_ADD, SRC_SIG, SRC_R1, 1'b0, 1'b0, SH_Q, DST_SIG);
			5'd18: u = mk(UK_MUL, SRC_KB, SRC_X1, 1'b0, 1'b0, SH_Q, DST_R0);
			5'd19: u = mk(UK_MUL, SRC_R0, SRC_Y, 1'b0, 1'b0, SH_Q, DST_R0);
			5'd20: u = mk(UK_ADD, SRC_SIG, SRC_R0, 1'b0, 1'b0, SH_Q, DST_TH);
			5'd21: u = mk(UK_ROOT, SRC_TH, SRC_TH, 1'b0, 1'b0, SH_Q, DST_NONE);
			5'd22: u = mk(UK_MUL, SRC_OMEGA, SRC_INV, 1'b0, 1'b0, SH_RAW, DST_FREQ);
			5'd23: u = mk(UK_END, SRC_A, SRC_A, 1'b0, 1'b0, SH_Q, DST_NONE);
			5'd24: u = mk(UK_MUL, SRC_A, SRC_A, 1'b0, 1'b0, SH_Q, DST_REINIT);
			default: u = mk(UK_HALT, SRC_A, SRC_A, 1'b0, 1'b0, SH_Q, DST_NONE);
		endcase
		return u;
	endfunction

endpackage

@@ src/sfe_mul.sv @@
// Serial multiplier: unsigned magnitudes, two multiplier bits per cycle.
`timescale 1ns / 1ps
module sfe_mul #(
	parameter int MW = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [MW-1:0]   ma,
	input  logic [MW-1:0]   mb,
	output logic [2*MW-1:0] prod,
	output logic            done
);
	localparam int DG = MW / 2;
	localparam int CW = $clog2(DG + 1);

	logic [2*MW-1:0] acc_q;
	logic [MW+1:0]   m1_q;
	logic [MW+1:0]   m3_q;
	logic [CW-1:0]   cnt_q;
	logic            run_q;
	logic            done_q;
	logic [MW+1:0]   addend;
	logic [MW+1:0]   sum;

	always_comb begin
		case (acc_q[1:0])
			2'd0: addend = '0;
			2'd1: addend = m1_q;
			2'd2: addend = m1_q << 1;
			default: addend = m3_q;
		endcase
		sum = (MW+2)'(acc_q[2*MW-1:MW]) + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DG);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= {{MW{1'b0}}, mb};
			m1_q  <= (MW+2)'(ma);
			m3_q  <= ((MW+2)'(ma) << 1) + (MW+2)'(ma);
		end else if (run_q) begin
			acc_q <= {sum, acc_q[MW-1:2]};
		end
	end

	assign prod = acc_q;
	assign done = done_q;
endmodule

@@ src/sfe_sqrt.sv @@
// Serial integer square root of a magnitude scaled up by the fraction bits.
`timescale 1ns / 1ps
module sfe_sqrt #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [W-1:0]           operand,
	output logic [(W+F+1)/2-1:0]   root,
	output logic                   done
);
	localparam int RW = (W + F + 1) / 2;
	localparam int CW = $clog2(RW + 1);

	logic [2*RW-1:0] rad_q;
	logic [RW+1:0]   rem_q;
	logic [RW-1:0]   root_q;
	logic [CW-1:0]   cnt_q;
	logic            run_q;
	logic            done_q;
	logic [RW+1:0]   cur;
	logic [RW+1:0]   trial;
	logic            ge;

	always_comb begin
		cur   = {rem_q[RW-1:0], rad_q[2*RW-1 -: 2]};
		trial = {root_q, 2'b01};
		ge    = (cur >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(RW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= ((2*RW)'(operand)) << F;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= ge ? (cur - trial) : cur;
			root_q <= {root_q[RW-2:0], ge};
		end
	end

	assign root = root_q;
	assign done = done_q;
endmodule

@@ src/sinusoid_frequency_estimator_top.sv @@
// Top level of the sinusoid frequency estimator: step controller, state and ports.
// Each word runs 16 serial multiplies, six saturating adds and a root, one step at a time.
// One shared two-bit-per-cycle multiplier serves every multiply, so a new word is taken
// only once the previous one has run through all its steps.
// A new word is taken while the previous result still waits in the output register.
// After reset the block spends one multiply reloading sigma and theta and stalls input.
`timescale 1ns / 1ps
module sinusoid_frequency_estimator_top #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [31:0]        wr_data,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic signed [31:0] sample,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] theta_estimate,
	output logic [30:0]        angular_frequency,
	output logic [30:0]        frequency_hz,
	output logic               saturated
);
	localparam int W   = DATA_WIDTH;
	localparam int F   = FRAC_BITS;
	// Multiplier operand width: wide enough for a data value and for the period.
	localparam int MW  = (((W > 32) ? W : 32) + 1) / 2 * 2;
	localparam int ADW = MW + 3;
	localparam int RW  = (W + F + 1) / 2;
	localparam logic signed [ADW-1:0] SMAX = ADW'({1'b0, {(W-1){1'b1}}});
	localparam logic signed [ADW-1:0] SMIN = -SMAX - 1;
	localparam logic [2*MW-1:0] LIMP = (2*MW)'({1'b0, {(W-1){1'b1}}});
	localparam logic [2*MW-1:0] LIMN = LIMP + 1'b1;

	// Configuration registers.
	logic [30:0] filter_coefficient_q;
	logic [30:0] observer_gain_q;
	logic [30:0] estimator_gain_q;
	logic [31:0] sample_period_q;

	// Observer state and working registers.
	logic signed [W-1:0] x1_q, sig_q, th_q, y_q;
	logic signed [W-1:0] r0_q, r1_q, xd_q, t1_q, t2_q, t3_q, kb_q;
	logic [RW-1:0]       omega_q;
	logic [30:0]         freq_q;
	logic                sat_q;

	// Output register.
	logic signed [31:0] theta_out_q;
	logic [30:0]        omega_out_q;
	logic [30:0]        freq_out_q;
	logic               sat_out_q;
	logic               result_valid_q;

	sfe_pkg::state_t             state_q;
	logic [sfe_pkg::STEP_W-1:0]  step_q;
	logic                        mwait_q;
	sfe_pkg::uop_t               uop;

	logic [W:0] a_s, b_s, k_s, y_s;
	logic signed [MW:0] va, vb;
	logic [MW-1:0]      mag_a, mag_b;
	logic               mneg;
	logic [2*MW-1:0]    mprod, mshift, mlim;
	logic               mdone, mstart;
	logic [W-1:0]       mlo;
	logic signed [W-1:0] mval;
	logic               mclip;
	logic signed [ADW-1:0] ea, eb, asum;
	logic [W:0]         add_s;
	logic [W-1:0]       th_mag;
	logic [RW-1:0]      sq_root;
	logic               sq_done, sq_start;
	logic               commit;
	logic signed [W-1:0] wval;
	logic               wclip;
	logic [W-1:0]       quarter;
	logic               out_free;
	logic               accept;
	logic signed [MW-1:0] th_ext;

	// Clip a wide value to the data range; the top bit reports a clip.
	function automatic logic [W:0] sat_w(input logic signed [ADW-1:0] v);
		logic [W:0] r;
		if (v > SMAX) begin
			r = {1'b1, SMAX[W-1:0]};
		end else if (v < SMIN) begin
			r = {1'b1, SMIN[W-1:0]};
		end else begin
			r = {1'b0, v[W-1:0]};
		end
		return r;
	endfunction

	function automatic logic signed [MW:0] src_val(input sfe_pkg::src_t s);
		logic signed [MW:0] v;
		case (s)
			sfe_pkg::SRC_A:     v = (MW+1)'($signed(a_s[W-1:0]));
			sfe_pkg::SRC_B:     v = (MW+1)'($signed(b_s[W-1:0]));
			sfe_pkg::SRC_K:     v = (MW+1)'($signed(k_s[W-1:0]));
			sfe_pkg::SRC_DT:    v = (MW+1)'(sample_period_q);
			sfe_pkg::SRC_Y:     v = (MW+1)'(y_q);
			sfe_pkg::SRC_X1:    v = (MW+1)'(x1_q);
			sfe_pkg::SRC_SIG:   v = (MW+1)'(sig_q);
			sfe_pkg::SRC_TH:    v = (MW+1)'(th_q);
			sfe_pkg::SRC_R0:    v = (MW+1)'(r0_q);
			sfe_pkg::SRC_R1:    v = (MW+1)'(r1_q);
			sfe_pkg::SRC_XD:    v = (MW+1)'(xd_q);
			sfe_pkg::SRC_T1:    v = (MW+1)'(t1_q);
			sfe_pkg::SRC_T2:    v = (MW+1)'(t2_q);
			sfe_pkg::SRC_T3:    v = (MW+1)'(t3_q);
			sfe_pkg::SRC_KB:    v = (MW+1)'(kb_q);
			sfe_pkg::SRC_OMEGA: v = (MW+1)'(omega_q);
			sfe_pkg::SRC_INV:   v = (MW+1)'(sfe_pkg::INV_TWO_PI_Q32);
			default:            v = '0;
		endcase
		return v;
	endfunction

	// Coefficients are clipped to the data range each time they are used.
	always_comb begin
		a_s = sat_w(ADW'(filter_coefficient_q));
		b_s = sat_w(ADW'(observer_gain_q));
		k_s = sat_w(ADW'(estimator_gain_q));
		y_s = sat_w(ADW'(sample));
	end

	always_comb begin
		uop   = sfe_pkg::ucode(step_q);
		va    = src_val(uop.sa);
		vb    = src_val(uop.sb);
		mag_a = va[MW] ? MW'(-va) : MW'(va);
		mag_b = vb[MW] ? MW'(-vb) : MW'(vb);
		mneg  = va[MW] ^ vb[MW];

		// The magnitude of the product is truncated, then clipped to the range unless the scaling is raw.
		mshift = (uop.sh == sfe_pkg::SH_32) ? (mprod >> 32) : (mprod >> F);
		mlim   = mneg ? LIMN : LIMP;
		mclip  = (uop.sh != sfe_pkg::SH_RAW) && (mshift > mlim);
		mlo    = mclip ? mlim[W-1:0] : mshift[W-1:0];
		mval   = mneg ? -$signed(mlo) : $signed(mlo);

		ea    = ADW'(va);
		eb    = ADW'(vb);
		asum  = (uop.na ? -ea : ea) + (uop.nb ? -eb : eb);
		add_s = sat_w(asum);

		th_mag  = th_q[W-1] ? W'(-th_q) : W'(th_q);
		quarter = mval >> 2;
	end

	sfe_mul #(.MW(MW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mstart),
		.ma     (mag_a),
		.mb     (mag_b),
		.prod   (mprod),
		.done   (mdone)
	);

	sfe_sqrt #(.W(W), .F(F)) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.operand (th_mag),
		.root    (sq_root),
		.done    (sq_done)
	);

	always_comb begin
		mstart   = (state_q == sfe_pkg::ST_BUSY) && (uop.kind == sfe_pkg::UK_MUL) && !mwait_q;
		sq_start = (state_q == sfe_pkg::ST_BUSY) && (uop.kind == sfe_pkg::UK_ROOT) && !mwait_q;
		commit   = (state_q == sfe_pkg::ST_BUSY) &&
			(((uop.kind == sfe_pkg::UK_MUL) && mwait_q && mdone) ||
			(uop.kind == sfe_pkg::UK_ADD));
		wval     = (uop.kind == sfe_pkg::UK_ADD) ? $signed(add_s[W-1:0]) : mval;
		wclip    = (uop.kind == sfe_pkg::UK_ADD) ? add_s[W] : mclip;
		out_free = !result_valid_q || !result_stall;
		accept   = (state_q == sfe_pkg::ST_IDLE) && sample_valid;
	end

	// Step controller. A coefficient write restarts the reload of sigma and theta.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= sfe_pkg::ST_BUSY;
			step_q         <= sfe_pkg::STEP_INIT;
			mwait_q        <= 1'b0;
			result_valid_q <= 1'b0;
			x1_q           <= '0;
			filter_coefficient_q <= 31'd1 << F;
			observer_gain_q      <= 31'd1 << F;
			estimator_gain_q     <= 31'd1 << F;
			sample_period_q      <= 32'd429497;
		end else begin
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				sfe_pkg::ST_IDLE: begin
					if (sample_valid) begin
						state_q <= sfe_pkg::ST_BUSY;
						step_q  <= sfe_pkg::STEP_FIRST;
						mwait_q <= 1'b0;
					end
				end
				sfe_pkg::ST_BUSY: begin
					case (uop.kind)
						sfe_pkg::UK_MUL: begin
							if (!mwait_q) begin
								mwait_q <= 1'b1;
							end else if (mdone) begin
								mwait_q <= 1'b0;
								step_q  <= step_q + 1'b1;
							end
						end
						sfe_pkg::UK_ROOT: begin
							if (!mwait_q) begin
								mwait_q <= 1'b1;
							end else if (sq_done) begin
								mwait_q <= 1'b0;
								step_q  <= step_q + 1'b1;
							end
						end
						sfe_pkg::UK_ADD: step_q <= step_q + 1'b1;
						sfe_pkg::UK_END: state_q <= sfe_pkg::ST_OUT;
						default: state_q <= sfe_pkg::ST_IDLE;
					endcase
					if (commit && (uop.dst == sfe_pkg::DST_X1)) begin
						x1_q <= wval;
					end
				end
				sfe_pkg::ST_OUT: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						state_q        <= sfe_pkg::ST_IDLE;
					end
				end
				default: state_q <= sfe_pkg::ST_IDLE;
			endcase
			if (wr_en) begin
				case (wr_index)
					sfe_pkg::REG_FILTER: filter_coefficient_q <= wr_data[30:0];
					sfe_pkg::REG_OBS:    observer_gain_q      <= wr_data[30:0];
					sfe_pkg::REG_EST:    estimator_gain_q     <= wr_data[30:0];
					default:             sample_period_q      <= wr_data;
				endcase
				if (wr_index != sfe_pkg::REG_PERIOD) begin
					state_q <= sfe_pkg::ST_BUSY;
					step_q  <= sfe_pkg::STEP_INIT;
					mwait_q <= 1'b0;
				end
			end
		end
	end

	assign th_ext = MW'(th_q);

	// Working registers and the output word.
	always_ff @(posedge clk) begin
		if (accept) begin
			y_q   <= $signed(y_s[W-1:0]);
			sat_q <= y_s[W] | a_s[W] | b_s[W] | k_s[W];
		end
		if (commit) begin
			if (uop.dst != sfe_pkg::DST_REINIT) begin
				sat_q <= sat_q | wclip;
			end
			case (uop.dst)
				sfe_pkg::DST_R0:   r0_q  <= wval;
				sfe_pkg::DST_R1:   r1_q  <= wval;
				sfe_pkg::DST_XD:   xd_q  <= wval;
				sfe_pkg::DST_T1:   t1_q  <= wval;
				sfe_pkg::DST_T2:   t2_q  <= wval;
				sfe_pkg::DST_T3:   t3_q  <= wval;
				sfe_pkg::DST_KB:   kb_q  <= wval;
				sfe_pkg::DST_SIG:  sig_q <= wval;
				sfe_pkg::DST_TH:   th_q  <= wval;
				sfe_pkg::DST_FREQ: freq_q <= mprod[62:32];
				sfe_pkg::DST_REINIT: begin
					// The square of a is never negative, so the quarter is a plain shift.
					sig_q <= -$signed(quarter);
					th_q  <= -$signed(quarter);
				end
				default: ;
			endcase
		end
		if ((state_q == sfe_pkg::ST_BUSY) && (uop.kind == sfe_pkg::UK_ROOT) &&
				mwait_q && sq_done) begin
			omega_q <= sq_root;
		end
		if ((state_q == sfe_pkg::ST_OUT) && out_free) begin
			theta_out_q <= th_ext[31:0];
			omega_out_q <= 31'(omega_q);
			freq_out_q  <= freq_q;
			sat_out_q   <= sat_q;
		end
	end

	assign sample_stall      = (state_q != sfe_pkg::ST_IDLE);
	assign result_valid      = result_valid_q;
	assign theta_estimate    = theta_out_q;
	assign angular_frequency = omega_out_q;
	assign frequency_hz      = freq_out_q;
	assign saturated         = sat_out_q;
endmodule
